/* src/pda_pkg.sv */
// Shared types, constants and codes of the parking distance alarm.
package pda_pkg;

	// Field and datapath widths
	localparam int CFG_W   = 14;
	localparam int TONE_W  = 10;
	localparam int VOL_W   = 10;
	localparam int IDX_W   = 3;
	localparam int PULSE_W = 32;
	localparam int PROD_W  = 37;  // pulse * 17
	localparam int DIST_W  = 27;  // distance after noise gate, <= 16383 * 5000
	localparam int NUM_W   = 29;  // dividend width, holds the tone numerator
	localparam int MM_W    = 14;
	localparam int DIGIT_W = 4;

	// Divider step count
	localparam int DIV_CNT_W = $clog2(NUM_W + 1);
	localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(NUM_W);

	// Millimeters: d / 5000 == ((d >> 3) * M) >> 34, exact for (d >> 3) below 2^24
	localparam int MM_PRE_SH = 3;
	localparam int MM_RECIP_W = 25;
	localparam logic [MM_RECIP_W-1:0] MM_RECIP = 25'd27487791;
	localparam int MM_RECIP_SH = 34;
	localparam int MM_PROD_W = DIST_W - MM_PRE_SH + MM_RECIP_W;
	localparam int MM_QUO_W = MM_PROD_W - MM_RECIP_SH;

	// Decimal split: x / 10 == (x * 0xCCCD) >> 19 for any 16-bit x
	localparam int DIGITS = 4;
	localparam int STEP_W = $clog2(DIGITS);
	localparam int RECIP_W = 17;
	localparam logic [RECIP_W-1:0] RECIP_10 = 17'd52429;
	localparam int RECIP_SH = 19;

	// Queue between front and back (power of two depth)
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Arithmetic constants
	localparam logic [12:0] MM_SCALE = 13'd5000;
	localparam logic [4:0] SOUND_NUM = 5'd17;
	localparam logic [NUM_W-1:0] TONE_NUM = 29'd500000000;
	localparam logic [MM_W-1:0] MM_CAP = 14'd9999;
	localparam logic [MM_W-1:0] TEN = 14'd10;
	localparam logic [TONE_W-1:0] TONE_MAX = 10'd1023;
	localparam logic [VOL_W-1:0] VOL_LOUD = 10'd30;
	localparam logic [VOL_W-1:0] VOL_MODERATE = 10'd20;

	// Display glyph codes
	localparam logic [DIGIT_W-1:0] GLYPH_O = 4'd0;
	localparam logic [DIGIT_W-1:0] GLYPH_S = 4'd10;
	localparam logic [DIGIT_W-1:0] GLYPH_T = 4'd11;
	localparam logic [DIGIT_W-1:0] GLYPH_P = 4'd12;
	localparam logic [DIGIT_W-1:0] GLYPH_BLANK = 4'd14;

	// Register indexes
	localparam logic [IDX_W-1:0] CFG_NOISE = 3'd0;
	localparam logic [IDX_W-1:0] CFG_STOP = 3'd1;
	localparam logic [IDX_W-1:0] CFG_NEAR = 3'd2;
	localparam logic [IDX_W-1:0] CFG_CLOSE_TONE = 3'd3;
	localparam logic [IDX_W-1:0] CFG_BASE_TONE = 3'd4;

	// Register reset values
	localparam logic [CFG_W-1:0] RST_NOISE = 14'd5000;
	localparam logic [CFG_W-1:0] RST_STOP = 14'd152;
	localparam logic [CFG_W-1:0] RST_NEAR = 14'd762;
	localparam logic [TONE_W-1:0] RST_CLOSE_TONE = 10'd800;
	localparam logic [TONE_W-1:0] RST_BASE_TONE = 10'd300;

	typedef enum logic [1:0] {
		CMD_READ   = 2'd0,
		CMD_ARM    = 2'd1,
		CMD_DISARM = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		BUZ_KEEP = 2'd0,
		BUZ_SET  = 2'd1,
		BUZ_OFF  = 2'd2
	} buz_t;

	typedef struct packed {
		logic [CFG_W-1:0]  noise;
		logic [CFG_W-1:0]  stop;
		logic [CFG_W-1:0]  near;
		logic [TONE_W-1:0] close_tone;
		logic [TONE_W-1:0] base_tone;
	} pda_cfg_t;

	// Classified item handed from front to back
	typedef struct packed {
		cmd_t              kind;
		logic              armed;
		logic              is_far;    // distance > stop threshold
		logic              is_close;  // distance < stop threshold
		logic              is_near;   // distance < near threshold
		logic [DIST_W-1:0] dist_units;
	} pda_entry_t;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  numer;
		logic [DIST_W-1:0] denom;
	} pda_div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} pda_div_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MM,
		ST_DIGIT,
		ST_TONE_CHK,
		ST_TONE_WAIT,
		ST_EMIT
	} back_state_t;

endpackage

/* src/pda_front.sv */
// Front end: accepts beats, scales the pulse, gates noise and classifies distance.
module pda_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pda_pkg::pda_cfg_t         cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                command,
	input  logic [pda_pkg::PULSE_W-1:0] pulse_count,
	output logic                      push,
	output pda_pkg::pda_entry_t       push_data,
	input  logic                      q_full
);
	import pda_pkg::*;

	logic              s1_valid_q;
	cmd_t              cmd_s1;
	logic [PROD_W-1:0] prod_s1;
	logic              armed_q;
	logic [DIST_W-1:0] noise_thr;
	logic [DIST_W-1:0] stop_thr;
	logic [DIST_W-1:0] near_thr;
	logic [DIST_W-1:0] gated_dist;

	// Handshake: stage 1 drains into the queue
	assign push = s1_valid_q && !q_full;
	assign in_ready = !s1_valid_q || !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	// Stage 1 payload: distance in 1/5000 mm units
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd_t'(command);
			prod_s1 <= PROD_W'(pulse_count) * PROD_W'(SOUND_NUM);
		end
	end

	// Armed flag follows the beats in queue order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
		end else if (push) begin
			if (cmd_s1 == CMD_ARM) begin
				armed_q <= 1'b1;
			end else if (cmd_s1 == CMD_DISARM) begin
				armed_q <= 1'b0;
			end
		end
	end

	// Thresholds in the same units as the distance
	assign noise_thr = DIST_W'(cfg.noise) * DIST_W'(MM_SCALE);
	assign stop_thr = DIST_W'(cfg.stop) * DIST_W'(MM_SCALE);
	assign near_thr = DIST_W'(cfg.near) * DIST_W'(MM_SCALE);

	// Noise gate: anything beyond the limit reads as zero
	assign gated_dist = (prod_s1 > PROD_W'(noise_thr)) ? '0 : prod_s1[DIST_W-1:0];

	always_comb begin
		push_data.kind = cmd_s1;
		push_data.armed = armed_q;
		push_data.is_far = gated_dist > stop_thr;
		push_data.is_close = gated_dist < stop_thr;
		push_data.is_near = gated_dist < near_thr;
		push_data.dist_units = gated_dist;
	end

endmodule

/* src/pda_queue.sv */
// Short queue of classified items between the front and back ends.
module pda_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pda_pkg::pda_entry_t push_data,
	output logic                full,
	input  logic                pop,
	output pda_pkg::pda_entry_t pop_data,
	output logic                not_empty
);
	import pda_pkg::*;

	pda_entry_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full = count_q == QCNT_W'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;
	assign pop_data = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue fill count beyond depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");
`endif

endmodule

/* src/pda_div.sv */
// Restoring divider, one quotient bit per cycle.
module pda_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pda_pkg::pda_div_req_t         req,
	output pda_pkg::pda_div_stat_t        stat,
	output logic [pda_pkg::NUM_W-1:0]     quotient
);
	import pda_pkg::*;

	logic [DIST_W-1:0]    rem_q;
	logic [DIST_W-1:0]    den_q;
	logic [NUM_W-1:0]     num_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [DIST_W:0]      rem_sh;
	logic [DIST_W:0]      rem_diff;
	logic                 ge;

	// One trial subtraction
	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign rem_diff = rem_sh - {1'b0, den_q};
	assign ge = rem_sh >= {1'b0, den_q};

	// Step counter and done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cnt_q == DIV_CNT_W'(1);
			if (req.start) begin
				cnt_q <= DIV_STEPS;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Dividend shifts out while quotient bits shift in
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.numer;
			den_q <= req.denom;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? rem_diff[DIST_W-1:0] : rem_sh[DIST_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	assign stat.busy = cnt_q != '0;
	assign stat.done = done_q;
	assign quotient = num_q;

endmodule

/* src/pda_back.sv */
// Back end: divides, splits digits, picks the buzzer tone and holds the result beat.
module pda_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pda_pkg::pda_cfg_t             cfg,
	input  logic                          q_valid,
	input  pda_pkg::pda_entry_t           q_data,
	output logic                          q_pop,
	output pda_pkg::pda_div_req_t         div_req,
	input  pda_pkg::pda_div_stat_t        div_stat,
	input  logic [pda_pkg::NUM_W-1:0]     div_quo,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          display_update,
	output logic [pda_pkg::DIGIT_W-1:0]   digit_ones,
	output logic [pda_pkg::DIGIT_W-1:0]   digit_tens,
	output logic [pda_pkg::DIGIT_W-1:0]   digit_hundreds,
	output logic [pda_pkg::DIGIT_W-1:0]   digit_thousands,
	output logic [1:0]                    buzzer_action,
	output logic [pda_pkg::TONE_W-1:0]    tone_hz,
	output logic [pda_pkg::VOL_W-1:0]     volume_permille,
	output logic                          led_update,
	output logic                          led_red
);
	import pda_pkg::*;

	back_state_t                   state_q;
	back_state_t                   state_d;
	pda_entry_t                    ent_q;
	logic [MM_W-1:0]               val_q;
	logic [MM_W-1:0]               mm_q;
	logic [DIGITS*DIGIT_W-1:0]     digs_q;
	logic [STEP_W-1:0]             step_q;
	logic [TONE_W-1:0]             tone_q;
	logic                          out_valid_q;
	logic                          want_div;
	logic                          emit;
	logic [MM_PROD_W-1:0]          mm_prod;
	logic [MM_QUO_W-1:0]           mm_raw;
	logic [MM_W+RECIP_W-1:0]       prod10;
	logic [MM_W-1:0]               q10;
	logic [DIGIT_W-1:0]            digit;
	logic [MM_W-1:0]               mm_cap;
	logic [TONE_W:0]               tone_sum;
	logic [TONE_W-1:0]             tone_new;
	logic                          r_disp;
	logic [DIGIT_W-1:0]            r_ones;
	logic [DIGIT_W-1:0]            r_tens;
	logic [DIGIT_W-1:0]            r_hund;
	logic [DIGIT_W-1:0]            r_thou;
	buz_t                          r_buz;
	logic [TONE_W-1:0]             r_tone;
	logic [VOL_W-1:0]              r_vol;
	logic                          r_led_upd;
	logic                          r_led;

	// Pitched tone needs the inverse term
	assign want_div = ent_q.armed && !ent_q.is_close && ent_q.is_near &&
		(ent_q.dist_units != '0);

	// Millimeters by reciprocal multiplication, capped at four digits
	assign mm_prod = MM_PROD_W'(ent_q.dist_units[DIST_W-1:MM_PRE_SH]) * MM_PROD_W'(MM_RECIP);
	assign mm_raw = mm_prod[MM_PROD_W-1:MM_RECIP_SH];
	assign mm_cap = (mm_raw > MM_QUO_W'(MM_CAP)) ? MM_CAP : mm_raw[MM_W-1:0];

	// Decimal digit step
	assign prod10 = (MM_W + RECIP_W)'(val_q) * (MM_W + RECIP_W)'(RECIP_10);
	assign q10 = MM_W'(prod10 >> RECIP_SH);
	assign digit = DIGIT_W'(val_q - MM_W'(q10 * TEN));

	// Saturating tone sum
	assign tone_sum = {1'b0, cfg.base_tone} + {1'b0, div_quo[TONE_W-1:0]};
	assign tone_new = ((|div_quo[NUM_W-1:TONE_W]) || tone_sum[TONE_W]) ?
		TONE_MAX : tone_sum[TONE_W-1:0];

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					if (q_data.kind != CMD_READ) begin
						state_d = ST_EMIT;
					end else if (q_data.is_far) begin
						state_d = ST_MM;
					end else begin
						state_d = ST_TONE_CHK;
					end
				end
			end
			ST_MM: begin
				state_d = ST_DIGIT;
			end
			ST_DIGIT: begin
				if (step_q == STEP_W'(DIGITS - 1)) begin
					state_d = ST_TONE_CHK;
				end
			end
			ST_TONE_CHK: begin
				state_d = want_div ? ST_TONE_WAIT : ST_EMIT;
			end
			ST_TONE_WAIT: begin
				if (div_stat.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		q_pop = (state_q == ST_IDLE) && q_valid;
		emit = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
		div_req.start = (state_q == ST_TONE_CHK) && want_div;
		div_req.numer = TONE_NUM;
		div_req.denom = ent_q.dist_units;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_q <= q_data;
			step_q <= '0;
			digs_q <= {GLYPH_S, GLYPH_T, GLYPH_O, GLYPH_P};
		end
		if (state_q == ST_MM) begin
			val_q <= mm_cap;
			mm_q <= mm_cap;
		end
		if (state_q == ST_DIGIT) begin
			digs_q <= {digit, digs_q[DIGITS*DIGIT_W-1:DIGIT_W]};
			val_q <= q10;
			step_q <= step_q + 1'b1;
		end
		if ((state_q == ST_TONE_WAIT) && div_stat.done) begin
			tone_q <= tone_new;
		end
	end

	// Result fields
	always_comb begin
		r_disp = 1'b0;
		r_ones = '0;
		r_tens = '0;
		r_hund = '0;
		r_thou = '0;
		r_buz = BUZ_KEEP;
		r_tone = '0;
		r_vol = '0;
		r_led_upd = 1'b0;
		r_led = 1'b0;
		unique case (ent_q.kind)
			CMD_READ: begin
				r_disp = 1'b1;
				r_ones = digs_q[DIGIT_W-1:0];
				r_tens = digs_q[2*DIGIT_W-1:DIGIT_W];
				r_hund = digs_q[3*DIGIT_W-1:2*DIGIT_W];
				r_thou = digs_q[4*DIGIT_W-1:3*DIGIT_W];
				// Leading blanks only on the numeric display
				if (ent_q.is_far) begin
					if (mm_q < MM_W'(10)) begin
						r_tens = GLYPH_BLANK;
					end
					if (mm_q < MM_W'(100)) begin
						r_hund = GLYPH_BLANK;
					end
					if (mm_q < MM_W'(1000)) begin
						r_thou = GLYPH_BLANK;
					end
				end
				if (ent_q.armed) begin
					if (ent_q.is_close) begin
						r_buz = BUZ_SET;
						r_tone = cfg.close_tone;
						r_vol = VOL_LOUD;
					end else if (ent_q.is_near) begin
						r_buz = BUZ_SET;
						r_tone = (ent_q.dist_units == '0) ? TONE_MAX : tone_q;
						r_vol = VOL_MODERATE;
					end else begin
						r_buz = BUZ_OFF;
					end
				end
			end
			CMD_ARM: begin
				r_led_upd = 1'b1;
				r_led = 1'b1;
			end
			CMD_DISARM: begin
				r_buz = BUZ_OFF;
				r_led_upd = 1'b1;
			end
			CMD_NONE: begin
				r_disp = 1'b0;
			end
			default: r_disp = 1'b0;
		endcase
	end

	// Output register
	always_ff @(posedge clk) begin
		if (emit) begin
			display_update <= r_disp;
			digit_ones <= r_ones;
			digit_tens <= r_tens;
			digit_hundreds <= r_hund;
			digit_thousands <= r_thou;
			buzzer_action <= r_buz;
			tone_hz <= r_tone;
			volume_permille <= r_vol;
			led_update <= r_led_upd;
			led_red <= r_led;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_stat.busy)
		else $error("divider started while busy");
	a_mm_far: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MM) |-> (ent_q.kind == CMD_READ) && ent_q.is_far)
		else $error("millimeter step for an item that needs none");
	a_set_volume: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (buzzer_action == BUZ_SET)) |->
		(volume_permille == VOL_LOUD) || (volume_permille == VOL_MODERATE))
		else $error("tone set with a bad volume");
`endif

endmodule

/* src/parking_distance_alarm.sv */
// Parking distance alarm: one result beat per input beat, in order.
// Arm, disarm and unknown commands pass the front stage, the queue and the emit step;
// a reading may also take the mm step, the digit split and the tone division.
// The back end works one item at a time; the front stage and a two-entry queue take
// new beats meanwhile.
// Reset: arst_n clears the queue, state, armed flag and restores register defaults.
module parking_distance_alarm (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pda_pkg::IDX_W-1:0]     cfg_index,
	input  logic [pda_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    command,
	input  logic [pda_pkg::PULSE_W-1:0]   pulse_count,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          display_update,
	output logic [pda_pkg::DIGIT_W-1:0]   digit_ones,
	output logic [pda_pkg::DIGIT_W-1:0]   digit_tens,
	output logic [pda_pkg::DIGIT_W-1:0]   digit_hundreds,
	output logic [pda_pkg::DIGIT_W-1:0]   digit_thousands,
	output logic [1:0]                    buzzer_action,
	output logic [pda_pkg::TONE_W-1:0]    tone_hz,
	output logic [pda_pkg::VOL_W-1:0]     volume_permille,
	output logic                          led_update,
	output logic                          led_red
);
	import pda_pkg::*;

	pda_cfg_t      cfg_q;
	logic          push;
	pda_entry_t    push_data;
	logic          q_full;
	logic          q_pop;
	pda_entry_t    q_data;
	logic          q_valid;
	pda_div_req_t  div_req;
	pda_div_stat_t div_stat;
	logic [NUM_W-1:0] div_quo;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.noise <= RST_NOISE;
			cfg_q.stop <= RST_STOP;
			cfg_q.near <= RST_NEAR;
			cfg_q.close_tone <= RST_CLOSE_TONE;
			cfg_q.base_tone <= RST_BASE_TONE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NOISE: cfg_q.noise <= cfg_data;
				CFG_STOP: cfg_q.stop <= cfg_data;
				CFG_NEAR: cfg_q.near <= cfg_data;
				CFG_CLOSE_TONE: cfg_q.close_tone <= cfg_data[TONE_W-1:0];
				CFG_BASE_TONE: cfg_q.base_tone <= cfg_data[TONE_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	pda_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.pulse_count (pulse_count),
		.push        (push),
		.push_data   (push_data),
		.q_full      (q_full)
	);

	pda_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_data),
		.not_empty (q_valid)
	);

	pda_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	pda_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.q_valid         (q_valid),
		.q_data          (q_data),
		.q_pop           (q_pop),
		.div_req         (div_req),
		.div_stat        (div_stat),
		.div_quo         (div_quo),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.display_update  (display_update),
		.digit_ones      (digit_ones),
		.digit_tens      (digit_tens),
		.digit_hundreds  (digit_hundreds),
		.digit_thousands (digit_thousands),
		.buzzer_action   (buzzer_action),
		.tone_hz         (tone_hz),
		.volume_permille (volume_permille),
		.led_update      (led_update),
		.led_red         (led_red)
	);

endmodule
